/* design/solg_pkg.sv */
package solg_pkg;

  // limb width of the split multipliers
  localparam int LIMB_W = 32;

  // fixed field widths
  localparam int TX_W     = 12;
  localparam int RX_W     = 15;
  localparam int RADIUS_W = 26;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6371000);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // per-request flags carried next to the wide math
  typedef struct packed {
    logic                   cc_neg;
    logic                   far_gt;
    logic                   d2_zero;
    logic signed [TX_W-1:0] tx;
  } side_t;

endpackage

/* design/solg_cfg_if.sv */
interface solg_cfg_if import solg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] sphere_radius;

  modport source (output valid, output sphere_radius, input ready);
  modport sink (input valid, input sphere_radius, output ready);
endinterface

/* design/solg_req_if.sv */
interface solg_req_if import solg_pkg::*; #(parameter int COORD_BITS = 27) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  logic signed [TX_W-1:0]       tx_power;

  modport source (output valid, output first_x, output first_y, output first_z,
                  output second_x, output second_y, output second_z,
                  output tx_power, input ready);
  modport sink (input valid, input first_x, input first_y, input first_z,
                input second_x, input second_y, input second_z,
                input tx_power, output ready);
endinterface

/* design/solg_res_if.sv */
interface solg_res_if import solg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   line_of_sight;
  logic signed [RX_W-1:0] rx_power;

  modport source (output valid, output line_of_sight, output rx_power, input ready);
  modport sink (input valid, input line_of_sight, input rx_power, output ready);
endinterface

/* design/solg_mul.sv */
module solg_mul import solg_pkg::*; #(
  parameter int A_W = 64,
  parameter int B_W = 64
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [A_W-1:0]       a_i,
  input  logic [B_W-1:0]       b_i,
  output logic [A_W+B_W-1:0]   p_o
);

  localparam int NA  = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int NB  = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int P_W = A_W + B_W;

  logic [NA*LIMB_W-1:0] a_pad;
  logic [NB*LIMB_W-1:0] b_pad;
  logic [2*LIMB_W-1:0]  pp_q [NA][NB];
  logic [P_W-1:0]       row_d [NA];
  logic [P_W-1:0]       row_q [NA];
  logic [P_W-1:0]       p_d;
  logic [P_W-1:0]       p_q;

  assign a_pad = (NA*LIMB_W)'(a_i);
  assign b_pad = (NB*LIMB_W)'(b_i);

  // partial products, one limb pair each
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= (2*LIMB_W)'(a_pad[LIMB_W*i +: LIMB_W])
                      * (2*LIMB_W)'(b_pad[LIMB_W*j +: LIMB_W]);
        end
      end
      row_q <= row_d;
      p_q   <= p_d;
    end
  end

  // row sums
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (P_W'(pp_q[i][j]) << (LIMB_W*j));
      end
    end
  end

  // final sum of rows
  always_comb begin
    p_d = '0;
    for (int i = 0; i < NA; i++) begin
      p_d = p_d + (row_q[i] << (LIMB_W*i));
    end
  end

  assign p_o = p_q;

endmodule

/* design/solg_queue.sv */
module solg_queue import solg_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_vld_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              push_rdy_o,
  output logic              pop_vld_o,
  output logic [DATA_W-1:0] pop_data_o,
  input  logic              pop_rdy_i
);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push, pop;

  assign push_rdy_o = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_vld_o  = count_q != '0;
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_rdy_i && pop_vld_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

/* design/solg_front.sv */
module solg_front import solg_pkg::*; #(
  parameter int COORD_BITS = 27,
  localparam int ITEM_W = 8*COORD_BITS + 3 + TX_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  solg_req_if.sink          req_i,
  output logic              item_vld_o,
  output logic [ITEM_W-1:0] item_o,
  input  logic              item_rdy_i
);

  localparam int C    = COORD_BITS;
  localparam int D_W  = C + 1;
  localparam int SQ_W = 2*C - 1;
  localparam int N_W  = 2*C;

  logic f1_vld_q, f2_vld_q, f1_en, f2_en;

  logic signed [C-1:0]    p1_in [3];
  logic signed [C-1:0]    p2_in [3];
  logic signed [2*C-1:0]  sq1_full [3];
  logic signed [2*C-1:0]  sq2_full [3];
  logic [SQ_W-1:0]        s1_d [3];
  logic [SQ_W-1:0]        s2_d [3];

  logic signed [C-1:0]    p1_q [3];
  logic signed [C-1:0]    p2_q [3];
  logic [SQ_W-1:0]        s1_q [3];
  logic [SQ_W-1:0]        s2_q [3];
  logic signed [TX_W-1:0] tx1_q;

  logic [N_W-1:0]         n1, n2, on_d;
  logic                   sel1;
  logic signed [C-1:0]    o_sel [3];
  logic signed [C-1:0]    t_sel [3];
  logic signed [D_W-1:0]  d_d [3];
  logic [ITEM_W-1:0]      item_d, item_q;

  // stall chain
  assign f2_en       = !f2_vld_q || item_rdy_i;
  assign f1_en       = !f1_vld_q || f2_en;
  assign req_i.ready = f1_en;
  assign item_vld_o  = f2_vld_q;
  assign item_o      = item_q;

  // squared distances from the centre
  always_comb begin
    p1_in[0] = req_i.first_x;
    p1_in[1] = req_i.first_y;
    p1_in[2] = req_i.first_z;
    p2_in[0] = req_i.second_x;
    p2_in[1] = req_i.second_y;
    p2_in[2] = req_i.second_z;
    for (int i = 0; i < 3; i++) begin
      sq1_full[i] = p1_in[i] * p1_in[i];
      sq2_full[i] = p2_in[i] * p2_in[i];
      s1_d[i]     = sq1_full[i][SQ_W-1:0];
      s2_d[i]     = sq2_full[i][SQ_W-1:0];
    end
  end

  // pick origin (farther point, ties to second) and direction
  always_comb begin
    n1   = N_W'(s1_q[0]) + N_W'(s1_q[1]) + N_W'(s1_q[2]);
    n2   = N_W'(s2_q[0]) + N_W'(s2_q[1]) + N_W'(s2_q[2]);
    sel1 = n1 > n2;
    on_d = sel1 ? n1 : n2;
    for (int i = 0; i < 3; i++) begin
      o_sel[i] = sel1 ? p1_q[i] : p2_q[i];
      t_sel[i] = sel1 ? p2_q[i] : p1_q[i];
      d_d[i]   = D_W'(t_sel[i]) - D_W'(o_sel[i]);
    end
    item_d = {tx1_q, on_d, d_d[2], d_d[1], d_d[0], o_sel[2], o_sel[1], o_sel[0]};
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (f1_en && req_i.valid) begin
      p1_q  <= p1_in;
      p2_q  <= p2_in;
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      tx1_q <= req_i.tx_power;
    end
    if (f2_en && f1_vld_q) begin
      item_q <= item_d;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else begin
      if (f1_en) f1_vld_q <= req_i.valid;
      if (f2_en) f2_vld_q <= f1_vld_q;
    end
  end

endmodule

/* design/solg_back.sv */
module solg_back import solg_pkg::*; #(
  parameter int COORD_BITS = 27,
  parameter int POWER_FRAC_BITS = 4,
  localparam int ITEM_W = 8*COORD_BITS + 3 + TX_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_vld_i,
  input  logic [ITEM_W-1:0]   item_i,
  output logic                item_rdy_o,
  input  logic [RADIUS_W-1:0] radius_i,
  solg_res_if.source          res_o
);

  localparam int C     = COORD_BITS;
  localparam int D_W   = C + 1;
  localparam int N_W   = 2*C;
  localparam int PR_W  = 2*C + 1;
  localparam int RR_W  = 2*RADIUS_W;
  localparam int K_W   = 2*C + 2;
  localparam int D2_W  = 2*C + 2;
  localparam int CCM_W = (N_W > RR_W) ? N_W : RR_W;
  localparam int CC_W  = CCM_W + 1;
  localparam int M_W   = 2*C + 1;
  localparam int HI_W  = 2*C + 3;
  localparam int MM_W  = 2*M_W;
  localparam int CD_W  = CCM_W + D2_W;
  localparam int HH_W  = 2*HI_W;
  localparam int Q_W   = ((MM_W > CD_W) ? MM_W : CD_W) + 2;
  localparam int CMP_W = (Q_W > HH_W) ? Q_W : HH_W;
  localparam logic signed [RX_W-1:0] RX_BLOCKED =
    RX_W'(-(1000 * (1 << POWER_FRAC_BITS)));

  logic       en;
  logic [7:0] vld_q;
  logic       out_vld_q;

  // unpacked request
  logic signed [C-1:0]     o_in [3];
  logic signed [D_W-1:0]   d_in [3];
  logic [N_W-1:0]          on_in;
  logic signed [TX_W-1:0]  tx_in;

  // stage 1
  logic signed [PR_W-1:0]  od_full [3];
  logic signed [2*D_W-1:0] dd_full [3];
  logic signed [PR_W-1:0]  od_q [3];
  logic [PR_W-1:0]         dd_q [3];
  logic [RR_W-1:0]         rr_q;
  logic [N_W-1:0]          on1_q;
  logic signed [TX_W-1:0]  tx1_q;

  // stage 2
  logic signed [K_W-1:0]   k_q;
  logic [D2_W-1:0]         d2_q;
  logic signed [CC_W-1:0]  cc_q;
  logic signed [TX_W-1:0]  tx2_q;

  // stage 3
  logic signed [K_W-1:0]   k_neg;
  logic signed [CC_W-1:0]  cc_negv;
  logic [M_W-1:0]          m_q;
  logic [CCM_W-1:0]        ccm_q;
  logic                    ccneg3_q, dz3_q;
  logic [D2_W-1:0]         d2_3_q;
  logic signed [TX_W-1:0]  tx3_q;

  // stage 4
  logic                    gt_d;
  logic [HI_W-1:0]         hi_q;
  logic [M_W-1:0]          lo_q, m4_q;
  logic [CCM_W-1:0]        ccm4_q;
  logic [D2_W-1:0]         d2_4_q;
  side_t                   side4_q;
  side_t                   side_q [3];

  // products
  logic [MM_W-1:0]         mm_p;
  logic [CD_W-1:0]         cd_p;
  logic [HH_W-1:0]         hh_p;
  logic [MM_W-1:0]         ll_p;

  // stage 8
  logic signed [Q_W-1:0]   mm_s, cd_s, q_d, q_q;
  logic [HH_W-1:0]         hh8_q;
  logic [MM_W-1:0]         ll8_q;
  side_t                   side8_q;

  // decision
  logic [CMP_W-1:0]        q_u;
  logic                    vis;
  logic                    los_q;
  logic signed [RX_W-1:0]  rx_q;

  // whole back pipeline advances when the output slot is free
  assign en         = !out_vld_q || res_o.ready;
  assign item_rdy_o = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_in[i]    = item_i[C*i +: C];
      d_in[i]    = item_i[3*C + D_W*i +: D_W];
      od_full[i] = o_in[i] * d_in[i];
      dd_full[i] = d_in[i] * d_in[i];
    end
    on_in = item_i[3*C + 3*D_W +: N_W];
    tx_in = item_i[ITEM_W-1 -: TX_W];
  end

  // magnitudes of signed terms
  assign k_neg   = -k_q;
  assign cc_negv = -cc_q;
  assign gt_d    = D2_W'(m_q) > d2_3_q;

  // q = k^2 - (|O|^2 - R^2) * |d|^2
  always_comb begin
    mm_s = Q_W'(mm_p);
    cd_s = Q_W'(cd_p);
    q_d  = side_q[2].cc_neg ? mm_s + cd_s : mm_s - cd_s;
  end

  // visibility test
  always_comb begin
    q_u = CMP_W'($unsigned(q_q));
    vis = !side8_q.d2_zero
       && (q_q[Q_W-1]
        || (q_u > CMP_W'(hh8_q))
        || (side8_q.far_gt && (CMP_W'(ll8_q) > q_u)));
  end

  // data stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        od_q[i] <= od_full[i];
        dd_q[i] <= dd_full[i][PR_W-1:0];
      end
      rr_q  <= RR_W'(radius_i) * RR_W'(radius_i);
      on1_q <= on_in;
      tx1_q <= tx_in;

      k_q   <= K_W'(od_q[0]) + K_W'(od_q[1]) + K_W'(od_q[2]);
      d2_q  <= D2_W'(dd_q[0]) + D2_W'(dd_q[1]) + D2_W'(dd_q[2]);
      cc_q  <= $signed({1'b0, CCM_W'(on1_q)}) - $signed({1'b0, CCM_W'(rr_q)});
      tx2_q <= tx1_q;

      m_q      <= k_q[K_W-1] ? M_W'(k_neg) : M_W'(k_q);
      ccm_q    <= cc_q[CC_W-1] ? CCM_W'(cc_negv) : CCM_W'(cc_q);
      ccneg3_q <= cc_q[CC_W-1];
      dz3_q    <= d2_q == '0;
      d2_3_q   <= d2_q;
      tx3_q    <= tx2_q;

      hi_q           <= HI_W'(m_q) + HI_W'(d2_3_q);
      lo_q           <= gt_d ? m_q - M_W'(d2_3_q) : '0;
      m4_q           <= m_q;
      ccm4_q         <= ccm_q;
      d2_4_q         <= d2_3_q;
      side4_q.cc_neg  <= ccneg3_q;
      side4_q.far_gt  <= gt_d;
      side4_q.d2_zero <= dz3_q;
      side4_q.tx      <= tx3_q;

      side_q[0] <= side4_q;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];

      q_q     <= q_d;
      hh8_q   <= hh_p;
      ll8_q   <= ll_p;
      side8_q <= side_q[2];

      los_q <= vis;
      rx_q  <= vis ? RX_W'(side8_q.tx) : RX_BLOCKED;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[6:0], item_vld_i};
      out_vld_q <= vld_q[7];
    end
  end

  // wide squares and products, three stages each
  solg_mul #(.A_W(M_W), .B_W(M_W)) u_mul_mm (
    .clk_i, .en_i(en), .a_i(m4_q), .b_i(m4_q), .p_o(mm_p)
  );
  solg_mul #(.A_W(CCM_W), .B_W(D2_W)) u_mul_cd (
    .clk_i, .en_i(en), .a_i(ccm4_q), .b_i(d2_4_q), .p_o(cd_p)
  );
  solg_mul #(.A_W(HI_W), .B_W(HI_W)) u_mul_hh (
    .clk_i, .en_i(en), .a_i(hi_q), .b_i(hi_q), .p_o(hh_p)
  );
  solg_mul #(.A_W(M_W), .B_W(M_W)) u_mul_ll (
    .clk_i, .en_i(en), .a_i(lo_q), .b_i(lo_q), .p_o(ll_p)
  );

  assign res_o.valid         = out_vld_q;
  assign res_o.line_of_sight = los_q;
  assign res_o.rx_power      = rx_q;

endmodule

/* design/sphere_occlusion_link_gate.sv */
// Line-of-sight gate: takes two endpoints in a sphere-centred frame and a
// transmit power, and reports whether the sphere (radius from the config
// channel) blocks the segment; the decision is exact, with no rounding.
// Blocked links return -1000 dBm in rx_power. A new request is taken every
// cycle unless a full queue stalls the front. A request passes the 2 front
// stages, the queue and the 9 back stages (4 setup stages, 3 multiplier
// stages, the q sum and the output register). The wide squares are built
// from 32-bit limb products summed over three pipeline stages. A 4-entry
// queue separates origin selection from the intersection math, so the front
// keeps taking requests while the output waits, until the queue fills. The
// user must write the radius only while no request is in flight; the block
// itself does not enforce this.
module sphere_occlusion_link_gate import solg_pkg::*; #(
  parameter int COORD_BITS = 27,
  parameter int POWER_FRAC_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  solg_cfg_if.sink    cfg_i,
  solg_req_if.sink    req_i,
  solg_res_if.source  res_o
);

  localparam int ITEM_W = 8*COORD_BITS + 3 + TX_W;
  localparam logic signed [RX_W-1:0] RX_BLOCKED =
    RX_W'(-(1000 * (1 << POWER_FRAC_BITS)));

  logic [RADIUS_W-1:0] radius_q;
  logic                fe_vld, fe_rdy, be_vld, be_rdy;
  logic [ITEM_W-1:0]   fe_item, be_item;

  // radius register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_i.valid) begin
      radius_q <= cfg_i.sphere_radius;
    end
  end

  // origin selection
  solg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .req_i,
    .item_vld_o(fe_vld), .item_o(fe_item), .item_rdy_i(fe_rdy)
  );

  // decoupling queue
  solg_queue #(.DATA_W(ITEM_W)) u_queue (
    .clk_i, .rst_ni,
    .push_vld_i(fe_vld), .push_data_i(fe_item), .push_rdy_o(fe_rdy),
    .pop_vld_o(be_vld), .pop_data_o(be_item), .pop_rdy_i(be_rdy)
  );

  // intersection math
  solg_back #(.COORD_BITS(COORD_BITS), .POWER_FRAC_BITS(POWER_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .item_vld_i(be_vld), .item_i(be_item), .item_rdy_o(be_rdy),
    .radius_i(radius_q), .res_o
  );

  // blocked results carry the fixed floor power
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.line_of_sight |-> res_o.rx_power == RX_BLOCKED)
    else $error("blocked result without floor power");

  // visible results carry a sign-extended transmit power
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.line_of_sight |->
      (res_o.rx_power[RX_W-1:TX_W-1] == '0) || (res_o.rx_power[RX_W-1:TX_W-1] == '1))
    else $error("visible result power out of transmit range");

  // front holds its request while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_vld && !fe_rdy |=> fe_vld && $stable(fe_item))
    else $error("front dropped a request on a full queue");

endmodule
